### rtl/ace_pkg.sv
// Shared constants for the accumulator CPU execute block: opcodes, output kinds, sizes.
package ace_pkg;

   localparam int DATA_DEPTH      = 256;
   localparam int DATA_AW         = 8;
   localparam int STACK_DEPTH_DEF = 256;

   localparam logic [6:0] OP_NOP    = 7'd0;
   localparam logic [6:0] OP_LOAD   = 7'd1;
   localparam logic [6:0] OP_STORE  = 7'd2;
   localparam logic [6:0] OP_CALL   = 7'd3;
   localparam logic [6:0] OP_RET    = 7'd4;
   localparam logic [6:0] OP_JMP    = 7'd5;
   localparam logic [6:0] OP_JPOS   = 7'd6;
   localparam logic [6:0] OP_JZERO  = 7'd7;
   localparam logic [6:0] OP_JNEG   = 7'd8;
   localparam logic [6:0] OP_JCARRY = 7'd9;
   localparam logic [6:0] OP_CLC    = 7'd10;
   localparam logic [6:0] OP_AND    = 7'd16;
   localparam logic [6:0] OP_OR     = 7'd17;
   localparam logic [6:0] OP_XOR    = 7'd18;
   localparam logic [6:0] OP_NOT    = 7'd19;
   localparam logic [6:0] OP_SHL    = 7'd20;
   localparam logic [6:0] OP_SHR    = 7'd21;
   localparam logic [6:0] OP_CMP    = 7'd22;
   localparam logic [6:0] OP_ADD    = 7'd32;
   localparam logic [6:0] OP_SUB    = 7'd33;
   localparam logic [6:0] OP_INC    = 7'd34;
   localparam logic [6:0] OP_DEC    = 7'd35;
   localparam logic [6:0] OP_ABS    = 7'd36;
   localparam logic [6:0] OP_IN     = 7'd48;
   localparam logic [6:0] OP_OUTNUM = 7'd49;
   localparam logic [6:0] OP_OUTCH  = 7'd50;
   localparam logic [6:0] OP_OUTCHN = 7'd51;
   localparam logic [6:0] OP_NOP2   = 7'd112;
   localparam logic [6:0] OP_NOP3   = 7'd113;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_NUM    = 2'd1;
   localparam logic [1:0] KIND_CHAR   = 2'd2;
   localparam logic [1:0] KIND_CHARNL = 2'd3;

endpackage

### rtl/accumulator_cpu_execute_top.sv
// Top level of the accumulator CPU execute block with data memory and return stack.
// An instruction is taken in one transfer. The data memory and return stack reads are
// registered at that edge; the ALU and write-back run when the result register is empty
// or being taken, and the result is registered. A new instruction can be taken every
// cycle, so the sustained rate is one instruction per cycle while the result side keeps
// up. A store or call is forwarded to an indirect operand read or return read of the very
// next instruction. Reading a data memory or stack entry that was never written gives an
// unspecified value.
module accumulator_cpu_execute_top
   import ace_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_indirect,
   input  logic [6:0] req_command,
   input  logic [7:0] req_operand,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_next_address,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_value,
   output logic [7:0] rsp_accumulator,
   output logic       rsp_carry,
   output logic       rsp_halted
);

   localparam int SLOT_W = $clog2(STACK_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(STACK_DEPTH - 1);
   localparam logic [SLOT_W-1:0] WRAP_SLOT = SLOT_W'(255 % STACK_DEPTH);

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [7:0] sp,
                                                  input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] r;
      if (sp == 8'hff || slot == LAST_SLOT) r = '0;
      else r = slot + SLOT_W'(1);
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_dec(input logic [7:0] sp,
                                                  input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] r;
      if (sp == 8'h00) r = WRAP_SLOT;
      else if (slot == '0) r = LAST_SLOT;
      else r = slot - SLOT_W'(1);
      return r;
   endfunction

   // memories
   logic [7:0] data_mem [DATA_DEPTH];
   logic [7:0] stack_mem [STACK_DEPTH];

   // architectural state
   logic [7:0]        acc_ff, acc_in;
   logic [7:0]        pc_ff, pc_in;
   logic [7:0]        sp_ff, sp_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              carry_ff, carry_in;
   logic              stopped_ff, stopped_in;

   // issue stage
   logic       s1_valid_ff;
   logic       s1_indirect_ff;
   logic [6:0] s1_command_ff;
   logic [7:0] s1_operand_ff;

   logic [7:0] dm_rd_ff, dm_fwd_data_ff;
   logic       dm_fwd_ff;
   logic [7:0] rs_rd_ff, rs_fwd_data_ff;
   logic       rs_fwd_ff;

   // result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_next_address_ff;
   logic [1:0] rsp_out_kind_ff;
   logic [7:0] rsp_out_value_ff;
   logic [7:0] rsp_accumulator_ff;
   logic       rsp_carry_ff;
   logic       rsp_halted_ff;

   logic              accept, fire;
   logic [7:0]        ex_d, ex_ret;
   logic [1:0]        ex_kind;
   logic [7:0]        ex_oval;
   logic [8:0]        ex_sum, ex_diff;
   logic              dm_we, rs_we;
   logic [SLOT_W-1:0] rs_ra;

   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   assign ex_d   = s1_indirect_ff ? (dm_fwd_ff ? dm_fwd_data_ff : dm_rd_ff) : s1_operand_ff;
   assign ex_ret = (rs_fwd_ff ? rs_fwd_data_ff : rs_rd_ff) + 8'd1;
   assign ex_sum  = {1'b0, acc_ff} + {1'b0, ex_d};
   assign ex_diff = {1'b0, acc_ff} - {1'b0, ex_d};

   assign dm_we = fire && !stopped_ff && s1_command_ff == OP_STORE;
   assign rs_we = fire && !stopped_ff && s1_command_ff == OP_CALL;
   assign rs_ra = slot_dec(sp_in, slot_in);

   always_comb begin
      acc_in     = acc_ff;
      carry_in   = carry_ff;
      pc_in      = pc_ff;
      sp_in      = sp_ff;
      slot_in    = slot_ff;
      stopped_in = stopped_ff;
      ex_kind    = KIND_NONE;
      ex_oval    = 8'd0;
      if (fire && !stopped_ff) begin
         pc_in = pc_ff + 8'd1;
         unique case (s1_command_ff)
            OP_NOP, OP_IN, OP_NOP2, OP_NOP3: begin
            end
            OP_LOAD: acc_in = ex_d;
            OP_STORE: begin
            end
            OP_CALL: begin
               sp_in   = sp_ff + 8'd1;
               slot_in = slot_inc(sp_ff, slot_ff);
               pc_in   = ex_d;
            end
            OP_RET: begin
               sp_in   = sp_ff - 8'd1;
               slot_in = slot_dec(sp_ff, slot_ff);
               pc_in   = ex_ret;
               acc_in  = ex_d;
            end
            OP_JMP: pc_in = ex_d;
            OP_JPOS: if (!acc_ff[7]) pc_in = ex_d;
            OP_JZERO: if (acc_ff == 8'd0) pc_in = ex_d;
            OP_JNEG: if (acc_ff[7]) pc_in = ex_d;
            OP_JCARRY: if (carry_ff) pc_in = ex_d;
            OP_CLC: carry_in = 1'b0;
            OP_AND: acc_in = acc_ff & ex_d;
            OP_OR:  acc_in = acc_ff | ex_d;
            OP_XOR: acc_in = acc_ff ^ ex_d;
            OP_NOT: acc_in = ~acc_ff;
            OP_SHL: acc_in = (ex_d[7:3] != 5'd0) ? 8'd0 : (acc_ff << ex_d[2:0]);
            OP_SHR: acc_in = (ex_d[7:3] != 5'd0) ? 8'd0 : (acc_ff >> ex_d[2:0]);
            OP_CMP: begin
               if ({1'b0, acc_ff[6:0]} > ex_d) acc_in = acc_ff[7] ? 8'hff : 8'h01;
               else if (acc_ff == ex_d) acc_in = 8'h00;
               else acc_in = acc_ff[7] ? 8'h01 : 8'hff;
            end
            OP_ADD: begin
               acc_in   = ex_sum[7:0];
               carry_in = ex_sum[8];
            end
            OP_SUB: begin
               acc_in   = ex_diff[7:0];
               carry_in = !ex_diff[8];
            end
            OP_INC: acc_in = acc_ff + 8'd1;
            OP_DEC: acc_in = acc_ff - 8'd1;
            OP_ABS: if (acc_ff[7]) acc_in = ~acc_ff + 8'd1;
            OP_OUTNUM: begin
               ex_kind = KIND_NUM;
               ex_oval = acc_ff;
            end
            OP_OUTCH: begin
               ex_kind = KIND_CHAR;
               ex_oval = acc_ff;
            end
            OP_OUTCHN: begin
               ex_kind = KIND_CHARNL;
               ex_oval = acc_ff;
            end
            default: begin
               stopped_in = 1'b1;
               pc_in      = pc_ff;
            end
         endcase
      end
   end

   // data memory: read on transfer, write at execute
   always_ff @(posedge clock) begin
      if (dm_we) begin
         data_mem[ex_d] <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dm_rd_ff       <= data_mem[req_operand];
         dm_fwd_ff      <= dm_we && ex_d == req_operand;
         dm_fwd_data_ff <= acc_ff;
      end
   end

   // return stack: read the slot below the post-execute pointer
   always_ff @(posedge clock) begin
      if (rs_we) begin
         stack_mem[slot_ff] <= pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rs_rd_ff       <= stack_mem[rs_ra];
         rs_fwd_ff      <= rs_we && slot_ff == rs_ra;
         rs_fwd_data_ff <= pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_indirect_ff <= req_indirect;
         s1_command_ff  <= req_command;
         s1_operand_ff  <= req_operand;
      end
      if (fire) begin
         rsp_next_address_ff <= stopped_ff ? pc_ff : pc_in;
         rsp_out_kind_ff     <= ex_kind;
         rsp_out_value_ff    <= ex_oval;
         rsp_accumulator_ff  <= acc_in;
         rsp_carry_ff        <= carry_in;
         rsp_halted_ff       <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         pc_ff        <= 8'd0;
         sp_ff        <= 8'd0;
         slot_ff      <= '0;
         carry_ff     <= 1'b0;
         stopped_ff   <= 1'b0;
      end else begin
         if (accept) s1_valid_ff <= 1'b1;
         else if (fire) s1_valid_ff <= 1'b0;
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         acc_ff     <= acc_in;
         pc_ff      <= pc_in;
         sp_ff      <= sp_in;
         slot_ff    <= slot_in;
         carry_ff   <= carry_in;
         stopped_ff <= stopped_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_address = rsp_next_address_ff;
   assign rsp_out_kind     = rsp_out_kind_ff;
   assign rsp_out_value    = rsp_out_value_ff;
   assign rsp_accumulator  = rsp_accumulator_ff;
   assign rsp_carry        = rsp_carry_ff;
   assign rsp_halted       = rsp_halted_ff;

endmodule
